>>> sv/block_buffer_tag_manager_defines.svh
// ----------------------------------------------------------------------------
// Block buffer tag manager assertion macros
// Concurrent assertion wrappers for the top-level RTL, removable with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BUFFER_TAG_MANAGER_DEFINES_SVH
`define BLOCK_BUFFER_TAG_MANAGER_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication: when ante holds, cons must hold.
`define BBTM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("block buffer tag manager assertion failed");
// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define BBTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("block buffer tag manager assertion failed");
`else
`define BBTM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BBTM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/bbtm_pkg.sv
// ----------------------------------------------------------------------------
// Block buffer tag manager package
// Sizes, action codes, ring helper and the controller/datapath interface.
// ----------------------------------------------------------------------------
package bbtm_pkg;

    localparam int NUM_BUFFERS = 8;
    localparam int BLOCK_BITS  = 15;
    localparam int IDX_W       = $clog2(NUM_BUFFERS);

    localparam int USER_W      = 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_IDX_W   = 3;
    localparam int OUT_USED_W  = OUT_IDX_W + 3 + BLOCK_BITS;

    localparam logic [BLOCK_BITS-1:0] BLOCK_MAX = {BLOCK_BITS{1'b1}};

    localparam logic [1:0] ACT_BLOCK  = 2'd0;
    localparam logic [1:0] ACT_BUFFER = 2'd1;
    localparam logic [1:0] ACT_UPDATE = 2'd2;
    localparam logic [1:0] ACT_EMPTY  = 2'd3;

    typedef struct packed {
        logic load_item;     // capture the requested block number
        logic use_offset;    // add the drive offset with saturation
        logic start_lookup;  // read the recent buffer's tag
        logic scan_step;     // read the next tag around the ring
        logic hit_found;     // the tag under compare matched
        logic rd_victim;     // read the victim's tag
        logic assign_buf;    // overwrite the victim's tag
        logic assign_read;   // the assignment needs a disk read
        logic mark_dirty;    // set the recent buffer's dirty bit
        logic clear_all;     // invalidate every tag
        logic res_recent;    // plain result naming the recent buffer
        logic load_out;      // move the result into the output register
    } cmd_t;

    typedef struct packed {
        logic match;         // tag under compare equals the requested block
        logic scan_end;      // next ring step would return to the recent buffer
        logic out_free;      // output register can take a new result
    } status_t;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
        ring_next = (i == IDX_W'(NUM_BUFFERS - 1)) ? '0 : i + 1'b1;
    endfunction

endpackage

>>> sv/block_buffer_tag_manager.sv
// ----------------------------------------------------------------------------
// Block buffer tag manager
// Keeps block-number and dirty tags for a ring of disk block buffers.
// ----------------------------------------------------------------------------
// Usage. Requests arrive as beats on the slave stream: tuser carries the
// action (block request, buffer assign, mark updated, empty all) and tdata
// carries the block number. Every request yields exactly one result beat on
// the master stream naming the buffer that is now the most recent one, with
// hit, read and write-back flags and the block number to write back.
// The block works on one request at a time. The tags sit in one RAM with a
// single registered read port, so the lookup compares one tag per cycle. It
// checks the recent buffer's tag first and then walks the ring; a miss
// checks every buffer before the victim's tag is read and overwritten. A
// buffer assign goes straight to the victim, while mark updated and empty
// all go straight to the result. The slave side is ready again as soon as the
// result is loaded. The drive offset is written through cfg_wr_en/cfg_wr_data;
// the user must do so only while idle, as the block itself does not enforce it.
// The result waits in an output register, so the next request is taken while
// an earlier result is still stalled by the receiver; the block only holds
// off when a new result is ready and the old one has not been taken.
// Reset clears both ring pointers, the drive offset and all tag valid and
// dirty flags at once, so every buffer reads as clean block 0 right away.
// ----------------------------------------------------------------------------
`include "block_buffer_tag_manager_defines.svh"

module block_buffer_tag_manager
    import bbtm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [BLOCK_BITS-1:0]  cfg_wr_data,    // drive_offset
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // block_number[14:0], zero pad
    input  logic [USER_W-1:0]      s_axis_tuser,   // action[1:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // buffer_index[2:0], was_hit[3],
                                                   // need_read[4], need_writeback[5],
                                                   // writeback_block[20:6], zero pad
);

    cmd_t    cmd;
    status_t status;

    // The controller decides the sequence; the datapath holds all tag state.
    bbtm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_action (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    bbtm_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (s_axis_tdata),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_data    (m_axis_tdata)
    );

    // A pending result is never overwritten by the next one.
    `BBTM_ASSERT_IMP(a_out_no_overwrite, clk, rst_n, cmd.load_out, status.out_free)
    // After a request beat the block is still busy with it in the next cycle.
    `BBTM_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_axis_tvalid && s_axis_tready,
                      !s_axis_tready)
    // A tag is overwritten only right after the victim's tag has been read.
    `BBTM_ASSERT_NEXT(a_victim_read_first, clk, rst_n, cmd.rd_victim, cmd.assign_buf)

endmodule

>>> sv/bbtm_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bbtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/bbtm_ctrl.sv
// ----------------------------------------------------------------------------
// Block buffer tag manager controller
// Sequences lookup, ring scan, victim assignment and result hand-off.
// ----------------------------------------------------------------------------
module bbtm_ctrl
    import bbtm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [USER_W-1:0] in_action,
    output logic              in_ready,
    input  status_t           status,
    output cmd_t              cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_ASSIGN = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       read_reg, read_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            read_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            read_reg  <= read_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        read_next  = read_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_action)
                        ACT_BLOCK:
                        begin
                            cmd.load_item    = 1'b1;
                            cmd.use_offset   = 1'b1;
                            cmd.start_lookup = 1'b1;
                            read_next        = 1'b1;
                            state_next       = ST_SCAN;
                        end
                        ACT_BUFFER:
                        begin
                            cmd.load_item = 1'b1;
                            cmd.rd_victim = 1'b1;
                            read_next     = 1'b0;
                            state_next    = ST_ASSIGN;
                        end
                        ACT_UPDATE:
                        begin
                            cmd.mark_dirty = 1'b1;
                            cmd.res_recent = 1'b1;
                            state_next     = ST_FINISH;
                        end
                        default:
                        begin
                            cmd.clear_all  = 1'b1;
                            cmd.res_recent = 1'b1;
                            state_next     = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (status.match)
                begin
                    cmd.hit_found = 1'b1;
                    state_next    = ST_FINISH;
                end
                else if (status.scan_end)
                begin
                    cmd.rd_victim = 1'b1;
                    state_next    = ST_ASSIGN;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_ASSIGN:
            begin
                cmd.assign_buf  = 1'b1;
                cmd.assign_read = read_reg;
                state_next      = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/bbtm_dp.sv
// ----------------------------------------------------------------------------
// Block buffer tag manager datapath
// Tag RAM, valid and dirty flags, ring pointers, compare and result registers.
// ----------------------------------------------------------------------------
module bbtm_dp
    import bbtm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [BLOCK_BITS-1:0]  cfg_wr_data,
    input  logic [IN_TDATA_W-1:0]  in_data,
    input  cmd_t                   cmd,
    output status_t                status,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [OUT_TDATA_W-1:0] out_data
);

    logic [BLOCK_BITS-1:0]  offset_reg;
    logic [BLOCK_BITS-1:0]  blk_reg, blk_next;
    logic [IDX_W-1:0]       addr_reg, addr_next;
    logic [IDX_W-1:0]       recent_reg, recent_next;
    logic [IDX_W-1:0]       victim_reg, victim_next;
    logic [NUM_BUFFERS-1:0] valid_reg, valid_next;
    logic [NUM_BUFFERS-1:0] dirty_reg, dirty_next;

    logic [IDX_W-1:0]       res_idx_reg, res_idx_next;
    logic                   res_hit_reg, res_hit_next;
    logic                   res_rd_reg, res_rd_next;
    logic                   res_wb_reg, res_wb_next;
    logic [BLOCK_BITS-1:0]  res_wbblk_reg, res_wbblk_next;

    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic [BLOCK_BITS-1:0]  in_block;
    logic [BLOCK_BITS:0]    sum;
    logic [BLOCK_BITS-1:0]  sat_block;
    logic [BLOCK_BITS-1:0]  ram_rd_data;
    logic [BLOCK_BITS-1:0]  tag_block;
    logic [IDX_W-1:0]       next_addr;
    logic [IDX_W-1:0]       vic_step;
    logic [IDX_W-1:0]       rd_addr;
    logic                   rd_en;

    assign in_block  = in_data[BLOCK_BITS-1:0];
    assign sum       = {1'b0, in_block} + {1'b0, offset_reg};
    assign sat_block = sum[BLOCK_BITS] ? BLOCK_MAX : sum[BLOCK_BITS-1:0];

    // A tag never written since reset or the last empty reads as clean block 0.
    assign tag_block = valid_reg[addr_reg] ? ram_rd_data : '0;
    assign next_addr = ring_next(addr_reg);
    assign vic_step  = ring_next(addr_reg);

    assign status.match    = (tag_block == blk_reg);
    assign status.scan_end = (next_addr == recent_reg);
    assign status.out_free = !out_valid_reg || out_ready;

    assign rd_en   = cmd.start_lookup | cmd.rd_victim | cmd.scan_step;
    assign rd_addr = cmd.start_lookup ? recent_reg :
                     cmd.rd_victim    ? victim_reg : next_addr;

    bbtm_ram #(
        .WIDTH (BLOCK_BITS),
        .DEPTH (NUM_BUFFERS)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (cmd.assign_buf),
        .wr_addr (addr_reg),
        .wr_data (blk_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        blk_next       = blk_reg;
        addr_next      = addr_reg;
        recent_next    = recent_reg;
        victim_next    = victim_reg;
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;
        res_idx_next   = res_idx_reg;
        res_hit_next   = res_hit_reg;
        res_rd_next    = res_rd_reg;
        res_wb_next    = res_wb_reg;
        res_wbblk_next = res_wbblk_reg;

        if (cmd.load_item)
        begin
            blk_next = cmd.use_offset ? sat_block : in_block;
        end
        if (cmd.start_lookup)
        begin
            addr_next = recent_reg;
        end
        else if (cmd.rd_victim)
        begin
            addr_next = victim_reg;
        end
        else if (cmd.scan_step)
        begin
            addr_next = next_addr;
        end

        if (cmd.hit_found)
        begin
            recent_next    = addr_reg;
            res_idx_next   = addr_reg;
            res_hit_next   = 1'b1;
            res_rd_next    = 1'b0;
            res_wb_next    = 1'b0;
            res_wbblk_next = '0;
        end

        if (cmd.assign_buf)
        begin
            // The victim pointer steps over the buffer that was recent before.
            victim_next          = (vic_step == recent_reg) ? ring_next(vic_step) : vic_step;
            recent_next          = addr_reg;
            valid_next[addr_reg] = 1'b1;
            dirty_next[addr_reg] = 1'b0;
            res_idx_next         = addr_reg;
            res_hit_next         = 1'b0;
            res_rd_next          = cmd.assign_read;
            res_wb_next          = dirty_reg[addr_reg];
            res_wbblk_next       = dirty_reg[addr_reg] ? tag_block : '0;
        end

        if (cmd.mark_dirty)
        begin
            dirty_next[recent_reg] = 1'b1;
        end
        if (cmd.clear_all)
        begin
            valid_next = '0;
            dirty_next = '0;
        end
        if (cmd.res_recent)
        begin
            res_idx_next   = recent_reg;
            res_hit_next   = 1'b0;
            res_rd_next    = 1'b0;
            res_wb_next    = 1'b0;
            res_wbblk_next = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {(OUT_TDATA_W - OUT_USED_W)'(0), res_wbblk_reg, res_wb_reg,
                              res_rd_reg, res_hit_reg, OUT_IDX_W'(res_idx_reg)};
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            recent_reg    <= '0;
            victim_reg    <= '0;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                offset_reg <= cfg_wr_data;
            end
            recent_reg    <= recent_next;
            victim_reg    <= victim_next;
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg       <= blk_next;
        addr_reg      <= addr_next;
        res_idx_reg   <= res_idx_next;
        res_hit_reg   <= res_hit_next;
        res_rd_reg    <= res_rd_next;
        res_wb_reg    <= res_wb_next;
        res_wbblk_reg <= res_wbblk_next;
        out_data_reg  <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> sim/block_buffer_tag_manager_tb.sv
// ----------------------------------------------------------------------------
// Block buffer tag manager testbench
// Streams block, buffer, update and empty requests into the tag manager under
// random source gaps and sink stalls, predicts every result beat with a
// shadow copy of the tag ring, and compares each result field by field.
// ----------------------------------------------------------------------------
module block_buffer_tag_manager_tb
    import bbtm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Run limits. A miss scans the whole ring, so the quiet time before a
    // register write and the tail at the end are sized from the ring depth.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int QUIET_CYCLES = 2 * NUM_BUFFERS + 8;
    localparam int TAIL_CYCLES  = 4 * NUM_BUFFERS + 16;
    localparam int MAX_WAIT     = 16;

    // Bit positions of the result fields inside m_axis_tdata.
    localparam int HIT_BIT = OUT_IDX_W;
    localparam int READ_BIT = OUT_IDX_W + 1;
    localparam int WB_BIT = OUT_IDX_W + 2;
    localparam int WB_BLOCK_LSB = OUT_IDX_W + 3;

    typedef enum logic [1:0] {
        ENTRY_BEAT,
        ENTRY_CFG,
        ENTRY_DRAIN
    } entry_kind_t;

    // One entry of the source queue: a request beat, a drive offset write or
    // a pause that lets every outstanding result come back.
    typedef struct {
        entry_kind_t           kind;
        logic [1:0]            action;
        logic [BLOCK_BITS-1:0] value;
    } stim_entry_t;

    typedef struct packed {
        logic [BLOCK_BITS-1:0] writeback_block;
        logic                  need_writeback;
        logic                  need_read;
        logic                  was_hit;
        logic [IDX_W-1:0]      buffer_index;
    } lookup_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [BLOCK_BITS-1:0]  cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [USER_W-1:0]      s_axis_tuser = ACT_BLOCK;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Shadow state of the tag ring: dirty bit on top of the block number.
    logic [BLOCK_BITS:0]    shadow_tags [NUM_BUFFERS];
    logic [IDX_W-1:0]       shadow_recent;
    logic [IDX_W-1:0]       shadow_victim;
    logic [BLOCK_BITS-1:0]  shadow_offset;

    stim_entry_t            pending_q [$];
    lookup_result_t         expected_lookups [$];

    int                     beats_queued = 0;
    int                     beats_taken = 0;
    int                     errors = 0;
    int                     cycle_count = 0;
    int                     gap_left = 0;
    int                     quiet = 0;
    int                     stall_left = 0;
    bit                     send_steady = 1'b0;
    bit                     recv_steady = 1'b0;

    block_buffer_tag_manager uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Steady mode gives stretches without any idling; otherwise each beat
    // draws its own wait.
    function automatic int draw_wait(input bit steady);
        return steady ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(NUM_BUFFERS - 1)) ? '0 : i + 1'b1;
    endfunction

    // Hands the victim buffer to blk. The victim pointer then moves one step,
    // and one more if that step would land on the buffer that was recent
    // before the assignment.
    function automatic lookup_result_t claim_victim(input logic [BLOCK_BITS-1:0] blk);
        lookup_result_t   r;
        logic [IDX_W-1:0] v;
        logic [IDX_W-1:0] n;
        r = '0;
        v = shadow_victim;
        n = wrap_inc(v);
        if (n == shadow_recent)
            n = wrap_inc(n);
        shadow_victim = n;
        if (shadow_tags[v][BLOCK_BITS])
        begin
            r.need_writeback = 1'b1;
            r.writeback_block = shadow_tags[v][BLOCK_BITS-1:0];
        end
        shadow_tags[v] = {1'b0, blk};
        shadow_recent = v;
        r.buffer_index = v;
        return r;
    endfunction

    // Works out the result of one accepted request and queues it.
    function automatic void predict_lookup(input logic [1:0] action,
                                           input logic [BLOCK_BITS-1:0] bn);
        lookup_result_t        r;
        logic [BLOCK_BITS:0]   sum;
        logic [BLOCK_BITS-1:0] blk;
        logic [IDX_W-1:0]      i;
        logic                  found;
        r = '0;
        r.buffer_index = shadow_recent;
        case (action)
            ACT_BLOCK:
            begin
                // The offset sum saturates at the largest block number.
                sum = {1'b0, bn} + {1'b0, shadow_offset};
                blk = sum[BLOCK_BITS] ? BLOCK_MAX : sum[BLOCK_BITS-1:0];
                if (shadow_tags[shadow_recent][BLOCK_BITS-1:0] == blk)
                begin
                    r.was_hit = 1'b1;
                end
                else
                begin
                    found = 1'b0;
                    i = wrap_inc(shadow_recent);
                    while (i != shadow_recent && !found)
                    begin
                        if (shadow_tags[i][BLOCK_BITS-1:0] == blk)
                            found = 1'b1;
                        else
                            i = wrap_inc(i);
                    end
                    if (found)
                    begin
                        r.was_hit = 1'b1;
                        r.buffer_index = i;
                        shadow_recent = i;
                    end
                    else
                    begin
                        r = claim_victim(blk);
                        r.need_read = 1'b1;
                    end
                end
            end
            ACT_BUFFER:
                r = claim_victim(bn);
            ACT_UPDATE:
                shadow_tags[shadow_recent][BLOCK_BITS] = 1'b1;
            ACT_EMPTY:
                foreach (shadow_tags[k])
                    shadow_tags[k] = '0;
            default:
                ;
        endcase
        expected_lookups.push_back(r);
    endfunction

    task automatic push_beat(input logic [1:0] action, input logic [BLOCK_BITS-1:0] bn);
        pending_q.push_back('{ENTRY_BEAT, action, bn});
        beats_queued++;
    endtask

    task automatic push_cfg(input logic [BLOCK_BITS-1:0] offset);
        pending_q.push_back('{ENTRY_CFG, ACT_BLOCK, offset});
    endtask

    task automatic push_drain();
        pending_q.push_back('{ENTRY_DRAIN, ACT_BLOCK, '0});
    endtask

    // Source side. A beat is held until it is taken; between beats the
    // source idles for the drawn number of cycles. Register writes and
    // pauses wait until every result is back and the block has been quiet
    // for a while, so that the offset never changes under a request.
    always @(posedge clk or negedge rst_n)
    begin : beat_driver
        stim_entry_t entry;
        logic        write_now;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= ACT_BLOCK;
            cfg_wr_en <= 1'b0;
            cfg_wr_data <= '0;
            gap_left <= 0;
            quiet <= 0;
        end
        else
        begin
            write_now = 1'b0;
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_lookup(s_axis_tuser, s_axis_tdata[BLOCK_BITS-1:0]);
                beats_taken <= beats_taken + 1;
            end
            if (s_axis_tvalid && !s_axis_tready)
            begin
                // The current beat stays on the bus until it is accepted.
            end
            else if (gap_left != 0)
            begin
                s_axis_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_q.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_q[0].kind == ENTRY_BEAT)
            begin
                entry = pending_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= entry.action;
                s_axis_tdata <= IN_TDATA_W'(entry.value);
                gap_left <= draw_wait(send_steady);
                send_steady <= send_steady ^ ($urandom_range(0, 47) == 0);
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
                if (expected_lookups.size() != 0)
                begin
                    quiet <= 0;
                end
                else if (quiet < QUIET_CYCLES)
                begin
                    quiet <= quiet + 1;
                end
                else
                begin
                    entry = pending_q.pop_front();
                    quiet <= 0;
                    if (entry.kind == ENTRY_CFG)
                    begin
                        write_now = 1'b1;
                        cfg_wr_data <= entry.value;
                        shadow_offset = entry.value;
                    end
                end
            end
            cfg_wr_en <= write_now;
        end
    end

    // Sink side. After each result beat the sink stalls for a drawn number
    // of cycles, then stays ready until the next beat arrives.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        lookup_result_t        exp_r;
        logic [IDX_W-1:0]      got_index;
        logic                  got_hit;
        logic                  got_read;
        logic                  got_wb;
        logic [BLOCK_BITS-1:0] got_wb_block;
        int                    stall;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            got_index = m_axis_tdata[OUT_IDX_W-1:0];
            got_hit = m_axis_tdata[HIT_BIT];
            got_read = m_axis_tdata[READ_BIT];
            got_wb = m_axis_tdata[WB_BIT];
            got_wb_block = m_axis_tdata[WB_BLOCK_LSB +: BLOCK_BITS];
            if (expected_lookups.size() == 0)
            begin
                $error("result beat with no request outstanding: tdata %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                exp_r = expected_lookups.pop_front();
                if (got_index != exp_r.buffer_index)
                begin
                    $error("buffer_index: expected %0d, got %0d",
                           exp_r.buffer_index, got_index);
                    errors++;
                end
                if (got_hit != exp_r.was_hit)
                begin
                    $error("was_hit: expected %0d, got %0d", exp_r.was_hit, got_hit);
                    errors++;
                end
                if (got_read != exp_r.need_read)
                begin
                    $error("need_read: expected %0d, got %0d", exp_r.need_read, got_read);
                    errors++;
                end
                if (got_wb != exp_r.need_writeback)
                begin
                    $error("need_writeback: expected %0d, got %0d",
                           exp_r.need_writeback, got_wb);
                    errors++;
                end
                if (got_wb_block != exp_r.writeback_block)
                begin
                    $error("writeback_block: expected %0d, got %0d",
                           exp_r.writeback_block, got_wb_block);
                    errors++;
                end
            end
            stall = draw_wait(recv_steady);
            stall_left <= stall;
            m_axis_tready <= (stall == 0);
            recv_steady <= recv_steady ^ ($urandom_range(0, 47) == 0);
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Fills the source queue, applies reset, and waits for the last result.
    initial
    begin : stimulus
        logic [BLOCK_BITS-1:0] offsets [8];
        logic [BLOCK_BITS-1:0] ws_base;
        logic [BLOCK_BITS-1:0] bn;
        int                    ws_size;
        int                    pick;

        foreach (shadow_tags[k])
            shadow_tags[k] = '0;
        shadow_recent = '0;
        shadow_victim = '0;
        shadow_offset = '0;

        // Directed part, offset at its reset value of zero. Right after reset
        // every tag is clean block 0, so block 0 hits.
        push_beat(ACT_BLOCK, '0);
        push_beat(ACT_UPDATE, '0);
        // The victim is the recent buffer itself and is dirty: write-back of
        // block 0 plus a read.
        push_beat(ACT_BLOCK, 15'd100);
        push_beat(ACT_BLOCK, BLOCK_MAX);
        push_beat(ACT_UPDATE, BLOCK_MAX);
        // Buffer assign takes the victim without a read.
        push_beat(ACT_BUFFER, BLOCK_MAX);
        // Hit found by a scan that wraps past the end of the ring.
        push_beat(ACT_BLOCK, 15'd100);
        // Empty all, then block 0 hits again.
        push_beat(ACT_EMPTY, BLOCK_MAX);
        push_beat(ACT_BLOCK, '0);
        for (int k = 1; k < NUM_BUFFERS; k++)
        begin
            push_beat(ACT_BLOCK, BLOCK_BITS'(k * 37));
            push_beat(ACT_UPDATE, '0);
        end
        // All buffers but the victim are dirty now; the victim was left clean
        // by the empty, so this miss evicts it without a write-back.
        push_beat(ACT_BLOCK, 15'd5);
        // Largest offset: the sum saturates at the top block number.
        push_drain();
        push_cfg(BLOCK_MAX);
        push_beat(ACT_BLOCK, 15'd1);
        push_beat(ACT_BUFFER, 15'h1234);

        // Random part in phases, each with its own drive offset and a small
        // working set of blocks so that hits, scans and write-backs all occur.
        offsets[0] = '0;
        offsets[1] = BLOCK_MAX;
        offsets[2] = BLOCK_BITS'($urandom);
        offsets[3] = 15'd1;
        offsets[4] = 15'h4000;
        offsets[5] = BLOCK_BITS'($urandom);
        offsets[6] = 15'h7FF0;
        offsets[7] = '0;
        for (int phase = 0; phase < 8; phase++)
        begin
            push_cfg(offsets[phase]);
            ws_base = BLOCK_BITS'($urandom);
            ws_size = $urandom_range(3, 14);
            for (int n = 0; n < 235; n++)
            begin
                if (n == 117)
                begin
                    // Pause until the block has answered everything, then
                    // move to a fresh working set.
                    push_drain();
                    ws_base = BLOCK_BITS'($urandom);
                    ws_size = $urandom_range(3, 14);
                end
                pick = $urandom_range(0, 99);
                bn = ws_base + BLOCK_BITS'($urandom_range(0, ws_size - 1));
                if (pick < 50)
                    push_beat(ACT_BLOCK, bn);
                else if (pick < 65)
                    push_beat(ACT_UPDATE, BLOCK_BITS'($urandom));
                else if (pick < 75)
                    push_beat(ACT_BLOCK, BLOCK_BITS'($urandom));
                else if (pick < 83)
                    push_beat(ACT_BUFFER, (pick < 79) ? bn : BLOCK_BITS'($urandom));
                else if (pick < 86)
                    push_beat(ACT_EMPTY, BLOCK_BITS'($urandom));
                else
                    push_beat(ACT_BLOCK, BLOCK_MAX - BLOCK_BITS'($urandom_range(0, ws_size)));
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (beats_taken != beats_queued || expected_lookups.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
